>>> sv/psm_pkg.sv
// Shared types and constants for the pulse speed meter.
package psm_pkg;

	localparam int TimeWidth   = 32;
	localparam int HistWidth   = 16;
	localparam int DistWidth   = 16;
	localparam int SpeedWidth  = 24;
	localparam int KmWidth     = 26;
	localparam int CountWidth  = 16;
	localparam int PeriodWidth = 32;
	localparam int CfgWidth    = 16;

	// divider: dividend is distance << 8, one quotient bit per step
	localparam int QuoWidth    = SpeedWidth;
	localparam int StepWidth   = $clog2(QuoWidth);
	localparam logic [StepWidth-1:0] LastStep = StepWidth'(QuoWidth - 1);

	// km speed: floor(speed*18/5), x = speed*18
	localparam int KmXWidth    = SpeedWidth + 5;
	localparam int RecipWidth  = 32;
	localparam int KmProdWidth = KmXWidth + RecipWidth;
	localparam logic [RecipWidth-1:0] RecipFive = 32'd858993459; // (2^32-1)/5

	localparam logic [HistWidth-1:0] HistForce  = 16'he000;
	localparam logic [HistWidth-1:0] HistAccept = 16'hf000;

	localparam logic [DistWidth-1:0] DistanceReset = 16'd4000;
	localparam logic [CfgWidth-1:0]  OffsetReset   = 16'd50;

	localparam logic OpTick = 1'b0;
	localparam logic OpEdge = 1'b1;

	typedef enum logic [0:0] {
		CFG_BAND_DISTANCE = 1'b0,
		CFG_PERIOD_OFFSET = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic op;
		logic pin_level;
	} item_t;

	typedef struct packed {
		logic [SpeedWidth-1:0]  speed_q8;
		logic [KmWidth-1:0]     speed_km_q8;
		logic [SpeedWidth-1:0]  max_speed_q8;
		logic [KmWidth-1:0]     max_speed_km_q8;
		logic [CountWidth-1:0]  pulse_count;
		logic [PeriodWidth-1:0] period_ms;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_KM_MUL,
		ST_KM_FIX,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic tick_acc;
		logic edge_acc;
		logic div_step;
		logic div_last;
		logic km_mul;
		logic km_fix;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pulse_hit;
		logic div_zero;
	} dp_status_t;

endpackage

>>> sv/psm_ctrl.sv
// Sequencer for the pulse speed meter: accept, divide, km scale, emit.
module psm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_op,
	output logic                 item_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  psm_pkg::dp_status_t  status,
	output psm_pkg::ctrl_cmd_t   cmd
);
	import psm_pkg::*;

	state_t               state_q, state_d;
	logic [StepWidth-1:0] step_q, step_d;
	logic                 result_valid_q, result_valid_d;
	logic                 take;
	logic                 slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			step_q         <= step_d;
			result_valid_q <= result_valid_d;
		end
	end

	assign take      = item_valid && (state_q == ST_IDLE);
	assign slot_free = !result_valid_q || !result_stall;

	always_comb begin
		state_d        = state_q;
		step_d         = step_q;
		cmd            = '0;
		result_valid_d = result_valid_q && result_stall;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (item_op == OpTick) begin
						cmd.tick_acc = 1'b1;
					end else begin
						cmd.edge_acc = 1'b1;
						if (status.pulse_hit) begin
							step_d  = LastStep;
							state_d = status.div_zero ? ST_KM_MUL : ST_DIV;
						end
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					cmd.div_last = 1'b1;
					state_d      = ST_KM_MUL;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			ST_KM_MUL: begin
				cmd.km_mul = 1'b1;
				state_d    = ST_KM_FIX;
			end
			ST_KM_FIX: begin
				cmd.km_fix = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit       = 1'b1;
					result_valid_d = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	a_hit_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.edge_acc && status.pulse_hit) |=> (state_q == ST_DIV || state_q == ST_KM_MUL))
		else $error("accepted pulse did not start the computation");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |=> (state_q == ST_KM_MUL))
		else $error("divider overran its step count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!result_valid_q || !result_stall))
		else $error("result register overwritten while held");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result valid raised outside emit");

endmodule

>>> sv/psm_datapath.sv
// Datapath: timestamp, debounce history, serial divider, km scaling, peaks, output register.
module psm_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  psm_pkg::cfg_index_t  cfg_index,
	input  logic [psm_pkg::CfgWidth-1:0] cfg_data,
	input  logic                 pin_level,
	input  psm_pkg::ctrl_cmd_t   cmd,
	output psm_pkg::dp_status_t  status,
	output psm_pkg::result_t     result
);
	import psm_pkg::*;

	logic [DistWidth-1:0]   distance_q;
	logic [CfgWidth-1:0]    offset_q;
	logic [HistWidth-1:0]   hist_q, hist_next;
	logic [TimeWidth-1:0]   ms_q, last_q, divisor_next, div_q;
	logic [CountWidth-1:0]  count_q;
	logic [SpeedWidth-1:0]  speed_q, speed_peak_q, speed_peak_next;
	logic [KmWidth-1:0]     km_peak_q, km_peak_next, km_q;
	logic [TimeWidth-1:0]   rem_q;
	logic [QuoWidth-1:0]    quo_q;
	logic [TimeWidth:0]     trial, diff;
	logic                   qbit;
	logic [KmXWidth-1:0]    km_x, km_x_q, km_est_q, km_five, km_rem, km_fixed;
	logic [KmProdWidth-1:0] km_prod;
	result_t                result_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_q <= DistanceReset;
			offset_q   <= OffsetReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BAND_DISTANCE: distance_q <= cfg_data;
				CFG_PERIOD_OFFSET: offset_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hist_next    = {hist_q[HistWidth-2:0], ~pin_level} | HistForce;
	assign divisor_next = ms_q - last_q + TimeWidth'(offset_q);
	assign status.pulse_hit = (hist_next == HistAccept);
	assign status.div_zero  = (divisor_next == '0);

	// restoring divider step
	assign trial = {rem_q, quo_q[QuoWidth-1]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = !diff[TimeWidth];

	// x*18 by shift-add, then /5 by reciprocal with one correction
	assign km_x     = (KmXWidth'(speed_q) << 4) + (KmXWidth'(speed_q) << 1);
	assign km_prod  = KmProdWidth'(km_x) * KmProdWidth'(RecipFive);
	assign km_five  = (km_est_q << 2) + km_est_q;
	assign km_rem   = km_x_q - km_five;
	assign km_fixed = (km_rem >= KmXWidth'(5)) ? km_est_q + 1'b1 : km_est_q;

	assign speed_peak_next = (speed_q > speed_peak_q) ? speed_q : speed_peak_q;
	assign km_peak_next    = (km_q > km_peak_q) ? km_q : km_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q       <= '0;
			ms_q         <= '0;
			last_q       <= '0;
			count_q      <= '0;
			speed_q      <= '0;
			speed_peak_q <= '0;
			km_peak_q    <= '0;
		end else begin
			if (cmd.tick_acc) begin
				ms_q <= ms_q + 1'b1;
			end
			if (cmd.edge_acc) begin
				hist_q <= hist_next;
				if (status.pulse_hit) begin
					count_q <= count_q + 1'b1;
					last_q  <= ms_q;
				end
			end
			if (cmd.div_last) begin
				speed_q <= {quo_q[QuoWidth-2:0], qbit};
			end
			if (cmd.emit) begin
				speed_peak_q <= speed_peak_next;
				km_peak_q    <= km_peak_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.edge_acc && status.pulse_hit) begin
			div_q <= divisor_next;
			rem_q <= '0;
			quo_q <= {distance_q, 8'h00};
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[QuoWidth-2:0], qbit};
			rem_q <= qbit ? diff[TimeWidth-1:0] : trial[TimeWidth-1:0];
		end
		if (cmd.km_mul) begin
			km_x_q   <= km_x;
			km_est_q <= km_prod[KmProdWidth-1:RecipWidth];
		end
		if (cmd.km_fix) begin
			km_q <= km_fixed[KmWidth-1:0];
		end
		if (cmd.emit) begin
			result_q.speed_q8        <= speed_q;
			result_q.speed_km_q8     <= km_q;
			result_q.max_speed_q8    <= speed_peak_next;
			result_q.max_speed_km_q8 <= km_peak_next;
			result_q.pulse_count     <= count_q;
			result_q.period_ms       <= PeriodWidth'(div_q);
		end
	end

	assign result = result_q;

endmodule

>>> sv/pulse_speed_meter_unit.sv
// Top level of the pulse speed meter: sequencer plus datapath.
//
//  channel  dir  handshake              payload
//  item     in   item_valid/item_stall  item_t   (op, pin_level)
//  result   out  result_valid/result_stall result_t (speeds, peaks, count, period)
//  cfg      in   cfg_we                 cfg_index, cfg_data
//
// A tick or a rejected edge is done in the accept alone. An accepted pulse runs the
// accept, the divider steps (one quotient bit each), the km multiply and correction,
// and the result load, waiting before the load while the result slot is held; the
// divider steps are skipped when period plus offset is zero.
// The result register holds a finished beat, so a new item is taken while it waits.
// Reset is asynchronous and needs no clearing pass.
module pulse_speed_meter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  psm_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output psm_pkg::result_t              result,
	input  logic                          cfg_we,
	input  psm_pkg::cfg_index_t           cfg_index,
	input  logic [psm_pkg::CfgWidth-1:0]  cfg_data
);
	import psm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	psm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_op      (item.op),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	psm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pin_level (item.pin_level),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule
